/* src/sacl_pkg.sv */
// shared types, constants and helpers for the set-associative tag lookup
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int unsigned WAYS     = 4;
  localparam int unsigned WAY_W    = 2;
  localparam int unsigned SETS     = 1024;
  localparam int unsigned SET_W    = 10;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INDEX_BITS  = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_REPLACE_LRU = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // rank 0 is most recently used
  typedef struct packed {
    logic [WAYS-1:0][WAY_W-1:0] rank;
    logic [WAYS-1:0]            valid;
  } meta_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    meta_t            meta;
    tag_row_t         tag_row;
  } lookup_t;

  function automatic meta_t meta_reset();
    meta_t m;
    m.valid = '0;
    for (int w = 0; w < WAYS; w++) begin
      m.rank[w] = WAY_W'(w);
    end
    return m;
  endfunction

endpackage

/* src/sacl_ram.sv */
// simple dual-port synchronous ram with registered read data
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sacl_lru_logic.sv */
// tag compare, victim choice and recency update for one set row
`timescale 1ns / 1ps

module sacl_lru_logic (
  input  logic [sacl_pkg::TAG_W-1:0] tag_i,
  input  sacl_pkg::tag_row_t         tag_row_i,
  input  sacl_pkg::meta_t            meta_i,
  input  logic                       replace_lru_i,
  output sacl_pkg::lookup_t          res_o
);
  import sacl_pkg::*;

  logic [WAYS-1:0]  match;
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] way;

  always_comb begin
    logic found;
    hit     = 1'b0;
    hit_way = '0;
    found   = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = meta_i.valid[w] && (tag_row_i[w] == tag_i);
      if (match[w] && !found) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    hit = found;
  end

  // in lru mode invalid ways first, lowest index; then oldest rank; otherwise way 0
  always_comb begin
    logic             found;
    logic [WAY_W-1:0] best;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] inv_way;
    found   = 1'b0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!meta_i.valid[w] && !found) begin
        found   = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    best    = meta_i.rank[0];
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (meta_i.rank[w] > best) begin
        best    = meta_i.rank[w];
        lru_way = WAY_W'(w);
      end
    end
    if (!replace_lru_i) begin
      victim = '0;
    end else if (found) begin
      victim = inv_way;
    end else begin
      victim = lru_way;
    end
  end

  assign way = hit ? hit_way : victim;

  always_comb begin
    logic [WAY_W-1:0] old;
    old          = meta_i.rank[way];
    res_o.hit    = hit;
    res_o.way    = way;
    res_o.meta   = meta_i;
    res_o.tag_row = tag_row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (meta_i.rank[w] < old) begin
        res_o.meta.rank[w] = meta_i.rank[w] + WAY_W'(1);
      end
    end
    res_o.meta.rank[way] = '0;
    if (!hit) begin
      res_o.meta.valid[way] = 1'b1;
      res_o.tag_row[way]    = tag_i;
    end
  end

endmodule

/* src/set_assoc_cache_tag_lookup_lru_core.sv */
// top level: set-associative tag lookup with lru replacement and hit/miss counters
// each address is held in set_q while its set row is read from ram, then the row is
// written back and the result registered; the core takes no new address until that
//   write-back is done, and a waiting result stalls the write-back
// reset: counters and configuration registers to defaults, then a pass clears the
//   valid bits and ranks of every set; s_axis_tready stays low until it ends
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_lru_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sacl_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // [31:0] address
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [9:0] set_index, [11:10] way, [43:12] hit_count, [75:44] miss_count, [79:76] zero
  output logic [79:0]                    m_axis_tdata,
  output logic                           m_axis_tuser    // [0] hit
);
  import sacl_pkg::*;

  state_e state_q, state_d;

  logic [CFG_DAT_W-1:0] index_bits_q, offset_bits_q;
  logic                 replace_lru_q;

  logic [SET_W-1:0] clr_q, clr_d;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic             out_hit_q;
  logic [SET_W-1:0] out_set_q;
  logic [WAY_W-1:0] out_way_q;

  logic             accept;
  logic             wb_go;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;
  logic [SET_W-1:0] set_mask;
  logic [ADDR_W-1:0] addr_sh;

  logic             meta_we;
  logic [SET_W-1:0] meta_waddr;
  meta_t            meta_wdata;
  meta_t            meta_rdata;
  tag_row_t         tag_rdata;
  lookup_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q  <= CFG_DAT_W'(10);
      offset_bits_q <= CFG_DAT_W'(6);
      replace_lru_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
        CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        CFG_REPLACE_LRU: replace_lru_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // address split; sets beyond the array fold onto the low index bits
  always_comb begin
    addr_sh  = s_axis_tdata >> offset_bits_q;
    set_mask = (index_bits_q >= CFG_DAT_W'(SET_W)) ? '1
             : SET_W'((11'(1) << index_bits_q) - 11'(1));
    in_set   = addr_sh[SET_W-1:0] & set_mask;
    in_tag   = s_axis_tdata >> (SHIFT_W'(index_bits_q) + SHIFT_W'(offset_bits_q));
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign wb_go  = (state_q == ST_LOOKUP) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    s_axis_tready = 1'b0;
    meta_we       = 1'b0;
    meta_waddr    = set_q;
    meta_wdata    = res.meta;
    case (state_q)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = meta_reset();
        clr_d      = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (wb_go) begin
          meta_we = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= in_set;
      tag_q <= in_tag;
    end
  end

  sacl_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (meta_rdata)
  );

  // whole row is written back; untouched ways keep what was read
  sacl_ram #(
    .WIDTH ($bits(tag_row_t)),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wb_go),
    .waddr_i (set_q),
    .wdata_i (res.tag_row),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (tag_rdata)
  );

  sacl_lru_logic u_lru (
    .tag_i         (tag_q),
    .tag_row_i     (tag_rdata),
    .meta_i        (meta_rdata),
    .replace_lru_i (replace_lru_q),
    .res_o         (res)
  );

  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (wb_go) begin
      out_valid_d = 1'b1;
      if (res.hit) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_d = hit_cnt_q + CNT_W'(1);
        end
      end else if (miss_cnt_q != '1) begin
        miss_cnt_d = miss_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_hit_q <= res.hit;
      out_set_q <= set_q;
      out_way_q <= res.way;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {4'b0000, miss_cnt_q, hit_cnt_q, out_way_q, out_set_q};

  // no new address may enter while the set memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("address taken during clearing pass");

  // the way written back is valid and most recently used
  a_wb_way_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go |-> (res.meta.valid[res.way] && (res.meta.rank[res.way] == '0)))
    else $error("written way not valid or not most recent");

  // exactly one counter moves per write-back unless saturated
  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go && (hit_cnt_q != '1) && (miss_cnt_q != '1) |=>
      ((hit_cnt_q - $past(hit_cnt_q)) + (miss_cnt_q - $past(miss_cnt_q))) == CNT_W'(1))
    else $error("hit/miss counters did not advance by one");

  // a write-back always leaves a result pending
  a_wb_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go |=> m_axis_tvalid)
    else $error("result lost after write-back");

endmodule

/* dv/tb_set_assoc_cache_tag_lookup_lru_core.sv */
// testbench for the set-associative tag lookup core with lru replacement
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lookup_lru_core;
  import sacl_pkg::*;

  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    logic             hit;
    logic [SET_W-1:0] set_idx;
    logic [WAY_W-1:0] way;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } access_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_INDEX_BITS;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [79:0]          m_axis_tdata;
  logic                 m_axis_tuser;

  set_assoc_cache_tag_lookup_lru_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the tag store, recency ranks and counters
  logic             way_valid [SETS][WAYS];
  logic [TAG_W-1:0] way_tag   [SETS][WAYS];
  logic [WAY_W-1:0] way_rank  [SETS][WAYS];
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [3:0]       cur_index_bits;
  logic [3:0]       cur_offset_bits;
  logic             cur_replace_lru;

  access_result_t pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles_left;
  int unsigned mismatches;
  int unsigned addresses_sent;
  int unsigned results_checked;
  int unsigned hits_seen;
  int unsigned cfg_writes;
  int unsigned stall_cycles;

  logic [TAG_W-1:0] hot_tags [6];
  logic [SET_W-1:0] hot_sets [3];

  function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr);
    access_result_t r;
    logic [63:0]      a;
    int unsigned      set_sel;
    int unsigned      victim;
    logic [TAG_W-1:0] tag_val;
    logic [WAY_W-1:0] old_rank;
    bit               found;
    bit               hit_now;
    a       = 64'(addr);
    set_sel = int'(((a >> cur_offset_bits) & ((64'd1 << cur_index_bits) - 64'd1)) % SETS);
    tag_val = TAG_W'(a >> (int'(cur_index_bits) + int'(cur_offset_bits)));
    hit_now = 1'b0;
    victim  = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_now && way_valid[set_sel][w] && way_tag[set_sel][w] == tag_val) begin
        hit_now = 1'b1;
        victim  = w;
      end
    end
    if (hit_now) begin
      if (hits_total != '1) hits_total++;
    end else begin
      if (misses_total != '1) misses_total++;
      if (cur_replace_lru) begin
        // empty ways are filled before any recency-based eviction
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
          if (!found && !way_valid[set_sel][w]) begin
            found  = 1'b1;
            victim = w;
          end
        end
        if (!found) begin
          for (int w = 1; w < WAYS; w++) begin
            if (way_rank[set_sel][w] > way_rank[set_sel][victim]) victim = w;
          end
        end
      end
      way_tag[set_sel][victim]   = tag_val;
      way_valid[set_sel][victim] = 1'b1;
    end
    old_rank = way_rank[set_sel][victim];
    for (int w = 0; w < WAYS; w++) begin
      if (way_rank[set_sel][w] < old_rank) way_rank[set_sel][w]++;
    end
    way_rank[set_sel][victim] = '0;
    r.hit     = hit_now;
    r.set_idx = SET_W'(set_sel);
    r.way     = WAY_W'(victim);
    r.hits    = hits_total;
    r.misses  = misses_total;
    return r;
  endfunction

  // place tag, set and offset where the current split expects them
  function automatic logic [ADDR_W-1:0] compose_address(input logic [31:0] tag_val,
                                                        input logic [31:0] set_val,
                                                        input logic [31:0] off_val);
    logic [63:0] a;
    a = 64'(tag_val) << (int'(cur_index_bits) + int'(cur_offset_bits));
    a |= (64'(set_val) & ((64'd1 << cur_index_bits) - 64'd1)) << cur_offset_bits;
    a |= 64'(off_val) & ((64'd1 << cur_offset_bits) - 64'd1);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [31:0] set_val;
    if ($urandom_range(99) < 25) return $urandom();
    if ($urandom_range(99) < 70) set_val = 32'(hot_sets[$urandom_range(2)]);
    else set_val = $urandom();
    return compose_address(hot_tags[$urandom_range(5)], set_val, $urandom());
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_access(addr));
    addresses_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e reg_sel, input logic [CFG_DAT_W-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (reg_sel)
      CFG_INDEX_BITS:  cur_index_bits  = val;
      CFG_OFFSET_BITS: cur_offset_bits = val;
      CFG_REPLACE_LRU: cur_replace_lru = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_split(input logic [3:0] ib, input logic [3:0] ob, input logic lru);
    write_reg(CFG_INDEX_BITS, ib);
    write_reg(CFG_OFFSET_BITS, ob);
    write_reg(CFG_REPLACE_LRU, CFG_DAT_W'(lru));
  endtask

  // defaults after reset: all-zero and all-one addresses, each followed by a repeat that hits
  task automatic test_reset_defaults();
    send_address(32'h0000_0000);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFFF);
  endtask

  // fill one set, touch the oldest way, then force evictions
  task automatic test_lru_eviction();
    for (int t = 1; t <= 4; t++) send_address(compose_address(t, 5, 0));
    send_address(compose_address(1, 5, 7));
    send_address(compose_address(5, 5, 0));
    send_address(compose_address(2, 5, 0));
  endtask

  // way-0 mode overwrites way 0 even with empty ways left in the set
  task automatic test_way0_mode();
    write_reg(CFG_REPLACE_LRU, '0);
    send_address(compose_address(1, 9, 0));
    send_address(compose_address(2, 9, 0));
    send_address(compose_address(1, 9, 0));
    send_address(compose_address(1, 9, 3));
  endtask

  // narrowest split of the address, then 10 index and 12 offset bits
  task automatic test_split_extremes();
    set_split(4'd0, 4'd0, 1'b1);
    send_address(32'h1234_5678);
    send_address(32'h1234_5678);
    send_address(32'h8000_0000);
    set_split(4'd10, 4'd12, 1'b1);
    send_address(32'hFFFF_FFFF);
    send_address(32'h003F_F000);
    send_address(32'h003F_FFFF);
  endtask

  task automatic test_random_phase(input int unsigned n_items, input logic [3:0] ib,
                                   input logic [3:0] ob, input logic lru);
    set_split(ib, ob, lru);
    foreach (hot_tags[i]) hot_tags[i] = $urandom();
    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom());
    repeat (n_items) send_address(random_address());
  endtask

  // output held off long enough for the core to stall its input
  task automatic test_backpressure();
    set_split(4'd3, 4'd6, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_cycles_left = 300;
    @(negedge clk_i);
    foreach (hot_tags[i]) hot_tags[i] = $urandom();
    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom());
    repeat (60) send_address(random_address());
  endtask

  initial begin
    foreach (way_valid[s, w]) begin
      way_valid[s][w] = 1'b0;
      way_tag[s][w]   = '0;
      way_rank[s][w]  = WAY_W'(w);
    end
    hits_total       = '0;
    misses_total     = '0;
    cur_index_bits   = 4'd10;
    cur_offset_bits  = 4'd6;
    cur_replace_lru  = 1'b1;
    send_idle_pct    = 8;
    recv_idle_pct    = 61;
    hold_cycles_left = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_lru_eviction();
    test_way0_mode();
    test_split_extremes();

    test_random_phase(170, 4'd10, 4'd6, 1'b1);
    test_random_phase(110, 4'd0, 4'd0, 1'b1);
    test_random_phase(120, 4'd10, 4'd12, 1'b0);
    send_idle_pct = 61;
    recv_idle_pct = 8;
    test_random_phase(170, 4'd4, 4'd4, 1'b1);
    test_random_phase(110, 4'd2, 4'd3, 1'b0);
    test_random_phase(120, 4'd7, 4'd12, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(170, 4'd10, 4'd12, 1'b1);
    test_random_phase(120, 4'd1, 4'd0, 1'b1);
    test_backpressure();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      mismatches += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("run covered %0d addresses, %0d results checked (%0d hits), %0d register writes",
             addresses_sent, results_checked, hits_seen, cfg_writes);
    $display("splits from 0/0 to 10/12 index/offset bits, lru and way-0 replacement");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    access_result_t got;
    access_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit     = m_axis_tuser;
      got.set_idx = m_axis_tdata[9:0];
      got.way     = m_axis_tdata[11:10];
      got.hits    = m_axis_tdata[43:12];
      got.misses  = m_axis_tdata[75:44];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result transaction: hit %0b set %0d way %0d",
                   got.hit, got.set_idx, got.way);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.hit) hits_seen++;
        if (got.hit !== want.hit || got.set_idx !== want.set_idx || got.way !== want.way ||
            got.hits !== want.hits || got.misses !== want.misses) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d mismatch: exp hit %0b set %0d way %0d hits %0d misses %0d",
                     results_checked, want.hit, want.set_idx, want.way, want.hits,
                     want.misses,
                     ", got hit %0b set %0d way %0d hits %0d misses %0d",
                     got.hit, got.set_idx, got.way, got.hits, got.misses);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", stall_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
